@@ hw/rtl/gjs_pkg.sv @@
// Shared types and constants of the Gauss-Jordan solver.
// No dependencies; the divider, the multiply-subtract and the solver core import this package.
package gjs_pkg;

  // Data and configuration widths fixed by the item format.
  localparam int unsigned DataW         = 32;
  localparam int unsigned CfgW          = 4;
  localparam int unsigned IndexOutW     = 3;
  localparam int unsigned FracW         = 16;
  localparam int unsigned MaxOrderDef   = 8;
  localparam logic [CfgW-1:0] OrderRst  = 4'd8;

  // Saturation limits of a signed Q16.16 value.
  localparam logic signed [DataW-1:0] SatMax = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] SatMin = 32'sh8000_0000;

  // Sequencer states of the solver.
  typedef enum logic [3:0] {
    S_LOAD,
    S_COPY_RD,
    S_COPY_WR,
    S_PIV_RD,
    S_PIV_CHK,
    S_DIV_RD,
    S_DIV_START,
    S_DIV_WAIT,
    S_ROW_SEL,
    S_F_CAP,
    S_EL_RD,
    S_EL_MUL,
    S_EL_WAIT,
    S_OUT_RD,
    S_OUT_HOLD
  } gjs_state_e;

endpackage

@@ hw/rtl/gjs_ram.sv @@
// Synchronous RAM with one write port and two registered read ports.
// Depends on nothing but its parameters.
module gjs_ram #(
  parameter int unsigned Depth = 72,
  parameter int unsigned AddrW = 7,
  parameter int unsigned Width = 32
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read ports; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

@@ hw/rtl/gjs_divider.sv @@
// Bit-serial Q16.16 divider with round to nearest and 32-bit saturation.
// Depends on gjs_pkg for widths and limits.
module gjs_divider
  import gjs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DataW-1:0] dividend_i,
  input  logic signed [DataW-1:0] divisor_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic signed [DataW-1:0] quot_o
);

  localparam int unsigned NumW = DataW + FracW + 1;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0]  num_q, quo_q;
  logic [DataW:0]   rem_q;
  logic [DataW-1:0] dmag_q;
  logic             neg_q, busy_q, done_q;
  logic [CntW-1:0]  cnt_q;

  logic [DataW:0]   x_mag, d_mag, rem_sh, rem_sub;
  logic [NumW-1:0]  num_init;
  logic             ge;
  logic signed [NumW:0] q_signed;

  // Magnitudes and rounded numerator |x|*2^16 + floor(|d|/2).
  always_comb begin
    x_mag    = dividend_i[DataW-1] ? (DataW+1)'(-$signed({dividend_i[DataW-1], dividend_i}))
                                   : {1'b0, dividend_i};
    d_mag    = divisor_i[DataW-1] ? (DataW+1)'(-$signed({divisor_i[DataW-1], divisor_i}))
                                  : {1'b0, divisor_i};
    num_init = NumW'({x_mag, {FracW{1'b0}}}) + NumW'(d_mag >> 1);
    rem_sh   = {rem_q[DataW-1:0], num_q[NumW-1]};
    ge       = rem_sh >= {1'b0, dmag_q};
    rem_sub  = rem_sh - {1'b0, dmag_q};
  end

  // One quotient bit per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      num_q  <= num_init;
      quo_q  <= '0;
      rem_q  <= '0;
      dmag_q <= d_mag[DataW-1:0];
      neg_q  <= dividend_i[DataW-1] ^ divisor_i[DataW-1];
    end else if (busy_q) begin
      num_q <= {num_q[NumW-2:0], 1'b0};
      quo_q <= {quo_q[NumW-2:0], ge};
      rem_q <= ge ? rem_sub : rem_sh;
    end
  end

  // Sign and saturation of the finished quotient.
  always_comb begin
    q_signed = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    if (q_signed > $signed((NumW+1)'(SatMax))) begin
      quot_o = SatMax;
    end else if (q_signed < $signed({{(NumW+1-DataW){1'b1}}, SatMin})) begin
      quot_o = SatMin;
    end else begin
      quot_o = q_signed[DataW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

@@ hw/rtl/gjs_mul_sub.sv @@
// Three-stage multiply-subtract: w - round(f*b / 2^16), saturated to 32 bits.
// Depends on gjs_pkg for widths and limits.
module gjs_mul_sub
  import gjs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic signed [DataW-1:0] factor_i,
  input  logic signed [DataW-1:0] pivot_row_i,
  input  logic signed [DataW-1:0] target_i,
  output logic                    valid_o,
  output logic signed [DataW-1:0] result_o
);

  localparam int unsigned ProdW = 2 * DataW;
  localparam int unsigned RndW  = ProdW - FracW + 1;

  logic [2:0]              vld_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [DataW-1:0] w1_q, w2_q;
  logic signed [RndW-1:0]  rp_q;
  logic signed [DataW-1:0] res_q;

  logic [ProdW-1:0]        p_mag;
  logic [ProdW-FracW-1:0]  m_mag;
  logic signed [RndW-1:0]  rp_d;
  logic signed [RndW:0]    diff;

  // Rounding of the product and saturated difference.
  always_comb begin
    p_mag = prod_q[ProdW-1] ? ProdW'(-prod_q) : prod_q;
    m_mag = (ProdW-FracW)'((p_mag + ProdW'(32'h8000)) >> FracW);
    rp_d  = prod_q[ProdW-1] ? -$signed({1'b0, m_mag}) : $signed({1'b0, m_mag});
    diff  = $signed({{(RndW+1-DataW){w2_q[DataW-1]}}, w2_q}) - $signed({rp_q[RndW-1], rp_q});
  end

  // Valid pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // Data pipeline: product, rounded product, saturated result.
  always_ff @(posedge clk_i) begin
    prod_q <= factor_i * pivot_row_i;
    w1_q   <= target_i;
    rp_q   <= rp_d;
    w2_q   <= w1_q;
    if (diff > $signed((RndW+1)'(SatMax))) begin
      res_q <= SatMax;
    end else if (diff < $signed({{(RndW+1-DataW){1'b1}}, SatMin})) begin
      res_q <= SatMin;
    end else begin
      res_q <= diff[DataW-1:0];
    end
  end

  assign valid_o  = vld_q[2];
  assign result_o = res_q;

endmodule

@@ hw/rtl/gauss_jordan_solver_core.sv @@
// Gauss-Jordan solver (no pivoting), signed Q16.16, N up to MAX_ORDER.
// Loading accepts one item per cycle. After the last item the loaded matrix is copied to scratch,
// then per pivot row come a check and N+1 divisions, and per other row N+1 multiply-subtracts,
// then one result per row, held while the output stalls; the serial divider and the single
// scratch-memory port pair set the pace. No item is taken until the run is out.
// Reset (async, active low) clears control state; the matrix memories are not cleared.
module gauss_jordan_solver_core
  import gjs_pkg::*;
#(
  parameter int unsigned MAX_ORDER = MaxOrderDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgW-1:0]        cfg_wdata_i,   // order_in_use
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [DataW-1:0]       s_axis_tdata,  // [31:0] element
  input  logic                   s_axis_tlast,  // is_last
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [DataW-1:0]       m_axis_tdata,  // [31:0] solution
  output logic [IndexOutW:0]     m_axis_tuser,  // [2:0] unknown_index, [3] singular
  output logic                   m_axis_tlast   // final_res
);

  localparam int unsigned Size  = MAX_ORDER * (MAX_ORDER + 1);
  localparam int unsigned AddrW = (Size > 1) ? $clog2(Size) : 1;
  localparam int unsigned PosW  = $clog2(Size + 1);
  localparam int unsigned IdxW  = $clog2(MAX_ORDER + 2);

  gjs_state_e state_q, state_d;

  logic [CfgW-1:0]  order_q;
  logic [PosW-1:0]  pos_q;
  logic [IdxW-1:0]  n_q, cols_q, k_q, row_q, col_q;
  logic [AddrW-1:0] cpy_q;
  logic             sing_q;
  logic signed [DataW-1:0] piv_q, f_q;
  logic             out_vld_q, out_last_q, out_sing_q;
  logic [IndexOutW-1:0] out_idx_q;
  logic [DataW-1:0] out_data_q;

  logic             in_acc, out_acc, out_load;
  logic [IdxW-1:0]  n_calc;
  logic [AddrW-1:0] a_rk, a_kc, a_kk, a_rn;
  logic             st_we, sc_we, sc_re;
  logic [AddrW-1:0] sc_waddr, sc_raddr;
  logic [DataW-1:0] sc_wdata, st_rdata, sc_rdata_a, sc_rdata_b;
  logic             div_start, div_busy, div_done, mul_vld, mul_done;
  logic signed [DataW-1:0] div_q, mul_res;
  logic             col_end, k_end, cpy_end;
  logic [31:0]      row_ext;

  function automatic logic [AddrW-1:0] addr_of(input logic [IdxW-1:0] r,
                                                input logic [IdxW-1:0] c,
                                                input logic [IdxW-1:0] cols);
    addr_of = AddrW'(AddrW'(r) * AddrW'(cols) + AddrW'(c));
  endfunction

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Order clamped to the supported range.
  always_comb begin
    if (order_q == '0) begin
      n_calc = IdxW'(1);
    end else if (32'(order_q) > MAX_ORDER) begin
      n_calc = IdxW'(MAX_ORDER);
    end else begin
      n_calc = IdxW'(order_q);
    end
  end

  // Addresses of the current row, pivot row and right-hand column.
  always_comb begin
    a_rk    = addr_of(row_q, col_q, cols_q);
    a_kc    = addr_of(k_q, col_q, cols_q);
    a_kk    = addr_of(k_q, k_q, cols_q);
    a_rn    = addr_of(row_q, n_q, cols_q);
    col_end = col_q == cols_q - 1'b1;
    k_end   = k_q == n_q - 1'b1;
    cpy_end = 32'(cpy_q) == 32'(n_q) * 32'(cols_q) - 1;
    row_ext = 32'(row_q);
  end

  // Sequencer: next state and memory controls.
  always_comb begin
    state_d   = state_q;
    st_we     = 1'b0;
    sc_we     = 1'b0;
    sc_re     = 1'b0;
    sc_waddr  = a_kc;
    sc_raddr  = a_rk;
    sc_wdata  = div_q;
    div_start = 1'b0;
    mul_vld   = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      S_LOAD: begin
        st_we = in_acc && (32'(pos_q) < Size);
        if (in_acc && s_axis_tlast) begin
          state_d = S_COPY_RD;
        end
      end
      S_COPY_RD: state_d = S_COPY_WR;
      S_COPY_WR: begin
        sc_we    = 1'b1;
        sc_waddr = cpy_q;
        sc_wdata = st_rdata;
        state_d  = cpy_end ? S_PIV_RD : S_COPY_RD;
      end
      S_PIV_RD: begin
        sc_re    = 1'b1;
        sc_raddr = a_kk;
        state_d  = S_PIV_CHK;
      end
      S_PIV_CHK: begin
        if (sc_rdata_a == '0) begin
          state_d = k_end ? S_OUT_RD : S_PIV_RD;
        end else begin
          state_d = S_DIV_RD;
        end
      end
      S_DIV_RD: begin
        sc_re    = 1'b1;
        sc_raddr = a_kc;
        state_d  = S_DIV_START;
      end
      S_DIV_START: begin
        div_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          sc_we   = 1'b1;
          state_d = col_end ? S_ROW_SEL : S_DIV_RD;
        end
      end
      S_ROW_SEL: begin
        if (row_q == n_q) begin
          state_d = k_end ? S_OUT_RD : S_PIV_RD;
        end else if (row_q != k_q) begin
          sc_re    = 1'b1;
          sc_raddr = addr_of(row_q, k_q, cols_q);
          state_d  = S_F_CAP;
        end
      end
      S_F_CAP: state_d = S_EL_RD;
      S_EL_RD: begin
        sc_re   = 1'b1;
        state_d = S_EL_MUL;
      end
      S_EL_MUL: begin
        mul_vld = 1'b1;
        state_d = S_EL_WAIT;
      end
      S_EL_WAIT: begin
        if (mul_done) begin
          sc_we    = 1'b1;
          sc_waddr = a_rk;
          sc_wdata = mul_res;
          state_d  = col_end ? S_ROW_SEL : S_EL_RD;
        end
      end
      S_OUT_RD: begin
        sc_re    = 1'b1;
        sc_raddr = a_rn;
        state_d  = S_OUT_HOLD;
      end
      S_OUT_HOLD: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = (row_q == n_q - 1'b1) ? S_LOAD : S_OUT_RD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration register and load position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= OrderRst;
      pos_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        if (s_axis_tlast) begin
          pos_q <= '0;
        end else if (32'(pos_q) < Size) begin
          pos_q <= pos_q + 1'b1;
        end
      end
    end
  end

  // Loop counters and the singular flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      cols_q <= '0;
      k_q    <= '0;
      row_q  <= '0;
      col_q  <= '0;
      cpy_q  <= '0;
      sing_q <= 1'b0;
    end else begin
      case (state_q)
        S_LOAD: begin
          if (in_acc && s_axis_tlast) begin
            n_q    <= n_calc;
            cols_q <= n_calc + 1'b1;
            cpy_q  <= '0;
            k_q    <= '0;
            sing_q <= 1'b0;
          end
        end
        S_COPY_WR: cpy_q <= cpy_q + 1'b1;
        S_PIV_CHK: begin
          col_q <= '0;
          if (sc_rdata_a == '0) begin
            sing_q <= 1'b1;
            k_q    <= k_q + 1'b1;
            row_q  <= '0;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            col_q <= col_q + 1'b1;
            if (col_end) begin
              row_q <= '0;
            end
          end
        end
        S_ROW_SEL: begin
          col_q <= '0;
          if (row_q == n_q) begin
            k_q   <= k_q + 1'b1;
            row_q <= '0;
          end else if (row_q == k_q) begin
            row_q <= row_q + 1'b1;
          end
        end
        S_EL_WAIT: begin
          if (mul_done) begin
            col_q <= col_q + 1'b1;
            if (col_end) begin
              row_q <= row_q + 1'b1;
            end
          end
        end
        S_OUT_HOLD: begin
          if (out_load) begin
            row_q <= row_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Pivot and row factor captures.
  always_ff @(posedge clk_i) begin
    if (state_q == S_PIV_CHK) begin
      piv_q <= sc_rdata_a;
    end
    if (state_q == S_F_CAP) begin
      f_q <= sc_rdata_a;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_acc) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= sc_rdata_a;
      out_idx_q  <= row_ext[IndexOutW-1:0];
      out_sing_q <= sing_q;
      out_last_q <= row_q == n_q - 1'b1;
    end
  end

  // Loaded matrix store.
  gjs_ram #(.Depth(Size), .AddrW(AddrW), .Width(DataW)) u_store (
    .clk_i     (clk_i),
    .we_i      (st_we),
    .waddr_i   (pos_q[AddrW-1:0]),
    .wdata_i   (s_axis_tdata),
    .re_i      (state_q == S_COPY_RD),
    .raddr_a_i (cpy_q),
    .raddr_b_i (cpy_q),
    .rdata_a_o (st_rdata),
    .rdata_b_o ()
  );

  // Scratch matrix; steps never read an entry written in the same cycle.
  gjs_ram #(.Depth(Size), .AddrW(AddrW), .Width(DataW)) u_scratch (
    .clk_i     (clk_i),
    .we_i      (sc_we),
    .waddr_i   (sc_waddr),
    .wdata_i   (sc_wdata),
    .re_i      (sc_re),
    .raddr_a_i (sc_raddr),
    .raddr_b_i (a_kc),
    .rdata_a_o (sc_rdata_a),
    .rdata_b_o (sc_rdata_b)
  );

  gjs_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sc_rdata_a),
    .divisor_i  (piv_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  gjs_mul_sub u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (mul_vld),
    .factor_i    (f_q),
    .pivot_row_i (sc_rdata_b),
    .target_i    (sc_rdata_a),
    .valid_o     (mul_done),
    .result_o    (mul_res)
  );

  assign s_axis_tready = state_q == S_LOAD;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = {out_sing_q, out_idx_q};
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // The divider is only started when idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_start |-> !div_busy)
    else $error("divider started while busy");
  // A multiply-subtract result only appears while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) mul_done |-> state_q == S_EL_WAIT)
    else $error("stray multiply-subtract result");
  // The load position never passes the store size.
  assert property (@(posedge clk_i) disable iff (!rst_ni) 32'(pos_q) <= Size)
    else $error("load position out of range");
  // A new output item is only loaded once the previous one is gone or taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_load |-> (!out_vld_q || m_axis_tready))
    else $error("output item overwritten");
`endif

endmodule
